[hw/rtl/cooperative_task_scheduler_top_assert.svh]
// Assertion macros shared by the scheduler RTL.
`ifndef COOPERATIVE_TASK_SCHEDULER_TOP_ASSERT_SVH
`define COOPERATIVE_TASK_SCHEDULER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CTS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/cts_pkg.sv]
// Types and constants for the cooperative task scheduler.
package cts_pkg;

  localparam int unsigned TASK_SLOTS  = 8;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned HANDLE_W    = 16;
  localparam int unsigned DELAY_W     = 16;
  localparam int unsigned PEND_W      = 8;
  localparam int unsigned DEL_W       = 3;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned EMIT_W      = $clog2(MAX_RESULTS);

  localparam logic [PEND_W-1:0] PENDING_MAX = 8'd255;

  localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 2'd3;

  localparam logic [KIND_W-1:0] KIND_ADD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  delay;
    logic [DELAY_W-1:0]  period;
    logic [PEND_W-1:0]   pending;
  } slot_rec_t;

  typedef struct packed {
    slot_rec_t rec;
    logic      emit;
    logic      ready;
    logic      keep;
  } slot_upd_t;

endpackage

[hw/rtl/cts_chan_if.sv]
// Command and result channel interfaces of the scheduler.
interface cts_in_if;
  logic                          valid;
  logic                          ready;
  logic [cts_pkg::CMD_W-1:0]     command;
  logic [cts_pkg::HANDLE_W-1:0]  task_handle;
  logic [cts_pkg::DELAY_W-1:0]   first_delay;
  logic [cts_pkg::DELAY_W-1:0]   repeat_period;
  logic [cts_pkg::DEL_W-1:0]     slot_to_delete;

  modport source (output valid, command, task_handle, first_delay, repeat_period,
                  slot_to_delete, input ready);
  modport sink (input valid, command, task_handle, first_delay, repeat_period,
                slot_to_delete, output ready);
endinterface

interface cts_out_if;
  logic                          valid;
  logic                          ready;
  logic [cts_pkg::KIND_W-1:0]    result_kind;
  logic [cts_pkg::SLOT_W-1:0]    slot_index;
  logic [cts_pkg::HANDLE_W-1:0]  run_handle;
  logic                          last_of_run;

  modport source (output valid, result_kind, slot_index, run_handle, last_of_run,
                  input ready);
  modport sink (input valid, result_kind, slot_index, run_handle, last_of_run,
                output ready);
endinterface

[hw/rtl/cts_slot_mem.sv]
// Slot table memory: one write port, one registered read port.
module cts_slot_mem #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = 3
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  cts_pkg::slot_rec_t wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output cts_pkg::slot_rec_t rd_data_r
);

  cts_pkg::slot_rec_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

endmodule

[hw/rtl/cts_slot_alu.sv]
// Shared per-slot update unit for tick and dispatch.
module cts_slot_alu (
  input  logic [cts_pkg::CMD_W-1:0] op,
  input  cts_pkg::slot_rec_t        rec_in,
  output cts_pkg::slot_upd_t        upd
);

  always_comb begin
    upd.rec  = rec_in;
    upd.emit = 1'b0;
    upd.keep = 1'b1;
    case (op)
      cts_pkg::CMD_TICK: begin
        if (rec_in.delay == '0) begin
          if (rec_in.pending != cts_pkg::PENDING_MAX) begin
            upd.rec.pending = rec_in.pending + 8'd1;
          end
          // periodic task: reload so it comes due again after period ticks
          if (rec_in.period != '0) begin
            upd.rec.delay = rec_in.period - 16'd1;
          end
        end else begin
          upd.rec.delay = rec_in.delay - 16'd1;
        end
      end
      cts_pkg::CMD_DISPATCH: begin
        if (rec_in.pending != '0) begin
          upd.emit        = 1'b1;
          upd.rec.pending = rec_in.pending - 8'd1;
          // one-shot task leaves the table after its first run
          if (rec_in.period == '0) begin
            upd.keep = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    upd.ready = upd.keep && (upd.rec.pending != '0);
  end

endmodule

[hw/rtl/cooperative_task_scheduler_top.sv]
// Tick and dispatch walk the slots in order, reading one while the one before goes through
// the update unit; a dispatch gives a result per ready slot, up to MAX_RESULTS, and a tick
// or a dispatch with none ready gives one at the end. Add scans for a free slot; delete
// frees the slot on accept. One command at a time; the next is accepted the cycle after
// the final result loads. Output stalls hold the walk. Reset (synchronous) frees all slots
// at once by clearing the occupancy and ready bits; the slot memory itself is not cleared.
`include "cooperative_task_scheduler_top_assert.svh"

module cooperative_task_scheduler_top (
  input  logic      clk,
  input  logic      rst_n,
  cts_in_if.sink    in_chan,
  cts_out_if.source out_chan
);

  localparam int unsigned TASK_SLOTS = cts_pkg::TASK_SLOTS;
  localparam int unsigned IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(TASK_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [cts_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [cts_pkg::HANDLE_W-1:0] handle_r;
  logic [cts_pkg::DELAY_W-1:0]  delay_r;
  logic [cts_pkg::DELAY_W-1:0]  period_r;
  logic [CNT_W-1:0]             idx_r, idx_nxt;
  logic                         pv_r, pv_nxt;
  logic [IDX_W-1:0]             proc_idx_r, proc_idx_nxt;
  logic [cts_pkg::EMIT_W-1:0]   emit_cnt_r, emit_cnt_nxt;
  logic [TASK_SLOTS-1:0]        occ_r, occ_nxt;
  logic [TASK_SLOTS-1:0]        rdy_r, rdy_nxt;
  logic [cts_pkg::KIND_W-1:0]   fin_kind_r, fin_kind_nxt;
  logic [cts_pkg::SLOT_W-1:0]   fin_slot_r, fin_slot_nxt;
  logic                         out_valid_r;
  logic [cts_pkg::KIND_W-1:0]   out_kind_r;
  logic [cts_pkg::SLOT_W-1:0]   out_slot_r;
  logic [cts_pkg::HANDLE_W-1:0] out_handle_r;
  logic                         out_last_r;

  logic                         accept;
  logic                         out_free;
  logic                         out_load;
  logic [cts_pkg::KIND_W-1:0]   ld_kind;
  logic [cts_pkg::SLOT_W-1:0]   ld_slot;
  logic [cts_pkg::HANDLE_W-1:0] ld_handle;
  logic                         ld_last;
  logic [IDX_W-1:0]             del_idx;
  logic [IDX_W-1:0]             scan_idx;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  cts_pkg::slot_rec_t           mem_wdata;
  logic                         rd_en;
  cts_pkg::slot_rec_t           rd_data;
  cts_pkg::slot_upd_t           upd;
  logic                         proc_live;
  logic                         stall;
  logic                         above_any;
  logic                         emit_last;

  cts_slot_mem #(
    .DEPTH (TASK_SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk       (clk),
    .wr_en     (mem_we),
    .wr_addr   (mem_waddr),
    .wr_data   (mem_wdata),
    .rd_en     (rd_en),
    .rd_addr   (scan_idx),
    .rd_data_r (rd_data)
  );

  cts_slot_alu u_alu (
    .op     (cmd_r),
    .rec_in (rd_data),
    .upd    (upd)
  );

  assign accept        = in_chan.valid && in_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign del_idx       = IDX_W'(in_chan.slot_to_delete);
  assign scan_idx      = idx_r[IDX_W-1:0];

  assign proc_live = pv_r && occ_r[proc_idx_r];
  assign stall     = proc_live && upd.emit && !out_free;

  // any ready slot left past the one being dispatched
  always_comb begin
    above_any = 1'b0;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      if (rdy_r[j] && (j > int'(proc_idx_r))) begin
        above_any = 1'b1;
      end
    end
  end

  assign emit_last = (emit_cnt_r == cts_pkg::EMIT_W'(cts_pkg::MAX_RESULTS - 1)) ||
                     !above_any;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    idx_nxt      = idx_r;
    pv_nxt       = pv_r;
    proc_idx_nxt = proc_idx_r;
    emit_cnt_nxt = emit_cnt_r;
    occ_nxt      = occ_r;
    rdy_nxt      = rdy_r;
    fin_kind_nxt = fin_kind_r;
    fin_slot_nxt = fin_slot_r;
    mem_we       = 1'b0;
    mem_waddr    = proc_idx_r;
    mem_wdata    = upd.rec;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    ld_kind      = fin_kind_r;
    ld_slot      = fin_slot_r;
    ld_handle    = '0;
    ld_last      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_chan.command;
          idx_nxt      = '0;
          pv_nxt       = 1'b0;
          emit_cnt_nxt = '0;
          case (in_chan.command)
            cts_pkg::CMD_TICK, cts_pkg::CMD_DISPATCH: begin
              state_nxt = S_WALK;
            end
            cts_pkg::CMD_ADD: begin
              if (in_chan.task_handle == '0) begin
                fin_kind_nxt = cts_pkg::KIND_ADD;
                fin_slot_nxt = cts_pkg::SLOT_W'(TASK_SLOTS);
                state_nxt    = S_FIN;
              end else begin
                state_nxt = S_FIND;
              end
            end
            cts_pkg::CMD_DELETE: begin
              if (32'(in_chan.slot_to_delete) < TASK_SLOTS) begin
                occ_nxt[del_idx] = 1'b0;
                rdy_nxt[del_idx] = 1'b0;
              end
              fin_kind_nxt = cts_pkg::KIND_DONE;
              fin_slot_nxt = '0;
              state_nxt    = S_FIN;
            end
            default: begin
            end
          endcase
        end
      end
      S_FIND: begin
        if (!occ_r[scan_idx]) begin
          mem_we            = 1'b1;
          mem_waddr         = scan_idx;
          mem_wdata.handle  = handle_r;
          mem_wdata.delay   = delay_r;
          mem_wdata.period  = period_r;
          mem_wdata.pending = '0;
          occ_nxt[scan_idx] = 1'b1;
          rdy_nxt[scan_idx] = 1'b0;
          fin_kind_nxt      = cts_pkg::KIND_ADD;
          fin_slot_nxt      = cts_pkg::SLOT_W'(idx_r);
          state_nxt         = S_FIN;
        end else if (idx_r == CNT_W'(TASK_SLOTS - 1)) begin
          fin_kind_nxt = cts_pkg::KIND_ADD;
          fin_slot_nxt = cts_pkg::SLOT_W'(TASK_SLOTS);
          state_nxt    = S_FIN;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_WALK: begin
        // read slot idx while slot proc_idx goes through the update unit
        if (!stall) begin
          if (idx_r != CNT_W'(TASK_SLOTS)) begin
            rd_en        = 1'b1;
            pv_nxt       = 1'b1;
            proc_idx_nxt = scan_idx;
            idx_nxt      = idx_r + CNT_W'(1);
          end else begin
            pv_nxt = 1'b0;
          end
          if (proc_live) begin
            mem_we              = 1'b1;
            occ_nxt[proc_idx_r] = upd.keep;
            rdy_nxt[proc_idx_r] = upd.ready;
            if (upd.emit) begin
              out_load     = 1'b1;
              ld_kind      = cts_pkg::KIND_RUN;
              ld_slot      = cts_pkg::SLOT_W'(proc_idx_r);
              ld_handle    = rd_data.handle;
              ld_last      = emit_last;
              emit_cnt_nxt = emit_cnt_r + cts_pkg::EMIT_W'(1);
              if (emit_last) begin
                state_nxt = S_IDLE;
              end
            end
          end
          if (!pv_r && (idx_r == CNT_W'(TASK_SLOTS))) begin
            fin_kind_nxt = (cmd_r == cts_pkg::CMD_TICK) ? cts_pkg::KIND_DONE
                                                        : cts_pkg::KIND_NONE;
            fin_slot_nxt = '0;
            state_nxt    = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmd_r       <= cts_pkg::CMD_TICK;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      proc_idx_r  <= '0;
      emit_cnt_r  <= '0;
      occ_r       <= '0;
      rdy_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmd_r       <= cmd_nxt;
      idx_r       <= idx_nxt;
      pv_r        <= pv_nxt;
      proc_idx_r  <= proc_idx_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      occ_r       <= occ_nxt;
      rdy_r       <= rdy_nxt;
      out_valid_r <= out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      handle_r <= in_chan.task_handle;
      delay_r  <= in_chan.first_delay;
      period_r <= in_chan.repeat_period;
    end
    fin_kind_r <= fin_kind_nxt;
    fin_slot_r <= fin_slot_nxt;
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_slot_r   <= ld_slot;
      out_handle_r <= ld_handle;
      out_last_r   <= ld_last;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.result_kind = out_kind_r;
  assign out_chan.slot_index  = out_slot_r;
  assign out_chan.run_handle  = out_handle_r;
  assign out_chan.last_of_run = out_last_r;

  `CTS_ASSERT_IMPLY(a_rdy_subset_occ, 1'b1, (rdy_r & ~occ_r) == '0, "ready bit on a free slot")
  `CTS_ASSERT_IMPLY(a_load_when_free, out_load, !out_valid_r || out_chan.ready, "result overrun")
  `CTS_ASSERT_IMPLY(a_no_port_clash, mem_we && rd_en, mem_waddr != scan_idx, "slot rw clash")
  `CTS_ASSERT_NEXT(a_last_to_idle, out_load && ld_last, state_r == S_IDLE, "busy after last")

endmodule

[dv/tb_cooperative_task_scheduler_top.sv]
// Self-checking testbench for the cooperative task scheduler: directed, saturation, random phases.
module tb_cooperative_task_scheduler_top;

  localparam int unsigned NSLOTS      = cts_pkg::TASK_SLOTS;
  localparam int unsigned RAND_ITEMS  = 28;
  localparam int unsigned SAT_TICKS   = 258;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LIMIT       = 100000;

  typedef struct packed {
    logic [cts_pkg::CMD_W-1:0]    command;
    logic [cts_pkg::HANDLE_W-1:0] handle;
    logic [cts_pkg::DELAY_W-1:0]  delay;
    logic [cts_pkg::DELAY_W-1:0]  period;
    logic [cts_pkg::DEL_W-1:0]    del_slot;
  } sched_cmd_t;

  typedef struct packed {
    logic [cts_pkg::KIND_W-1:0]   kind;
    logic [cts_pkg::SLOT_W-1:0]   slot;
    logic [cts_pkg::HANDLE_W-1:0] handle;
    logic                         last;
  } sched_res_t;

  // Slot table mirror and the queue of results still owed by the block.
  class sched_scoreboard;
    bit [cts_pkg::HANDLE_W-1:0] slot_hdl[NSLOTS];
    bit [cts_pkg::DELAY_W-1:0]  slot_dly[NSLOTS];
    bit [cts_pkg::DELAY_W-1:0]  slot_per[NSLOTS];
    bit [cts_pkg::PEND_W-1:0]   slot_pend[NSLOTS];
    sched_res_t                 expected_q[$];
    int unsigned                errors;
    int unsigned                checked;
    int unsigned                runs_seen;
    int unsigned                sat_hits;
    int unsigned                refused_adds;

    function void expect_result(logic [cts_pkg::KIND_W-1:0] kind,
                                logic [cts_pkg::SLOT_W-1:0] slot,
                                logic [cts_pkg::HANDLE_W-1:0] handle, logic last);
      sched_res_t r;
      r.kind   = kind;
      r.slot   = slot;
      r.handle = handle;
      r.last   = last;
      expected_q.push_back(r);
    endfunction

    function void clear_slot(int unsigned s);
      slot_hdl[s]  = '0;
      slot_dly[s]  = '0;
      slot_per[s]  = '0;
      slot_pend[s] = '0;
    endfunction

    // Advance the mirror by one accepted command and queue what it must produce.
    function void note_command(sched_cmd_t c);
      int unsigned found;
      int unsigned n;
      case (c.command)
        cts_pkg::CMD_TICK: begin
          for (int unsigned s = 0; s < NSLOTS; s++) begin
            if (slot_hdl[s] == 0) continue;
            if (slot_dly[s] == 0) begin
              if (slot_pend[s] < cts_pkg::PENDING_MAX) slot_pend[s]++;
              else sat_hits++;
              if (slot_per[s] != 0) slot_dly[s] = slot_per[s] - 1'b1;
            end else begin
              slot_dly[s]--;
            end
          end
          expect_result(cts_pkg::KIND_DONE, '0, '0, 1'b1);
        end
        cts_pkg::CMD_ADD: begin
          found = NSLOTS;
          if (c.handle != 0) begin
            for (int unsigned s = 0; s < NSLOTS; s++) begin
              if (slot_hdl[s] == 0) begin
                found = s;
                break;
              end
            end
          end
          if (found < NSLOTS) begin
            slot_hdl[found]  = c.handle;
            slot_dly[found]  = c.delay;
            slot_per[found]  = c.period;
            slot_pend[found] = '0;
          end else begin
            refused_adds++;
          end
          expect_result(cts_pkg::KIND_ADD, cts_pkg::SLOT_W'(found), '0, 1'b1);
        end
        cts_pkg::CMD_DELETE: begin
          if (c.del_slot < NSLOTS) clear_slot(32'(c.del_slot));
          expect_result(cts_pkg::KIND_DONE, '0, '0, 1'b1);
        end
        default: begin
          n = 0;
          for (int unsigned s = 0; s < NSLOTS && n < cts_pkg::MAX_RESULTS; s++) begin
            if (slot_hdl[s] == 0 || slot_pend[s] == 0) continue;
            expect_result(cts_pkg::KIND_RUN, cts_pkg::SLOT_W'(s), slot_hdl[s], 1'b0);
            n++;
            slot_pend[s]--;
            if (slot_per[s] == 0) clear_slot(s);
          end
          if (n == 0) expect_result(cts_pkg::KIND_NONE, '0, '0, 1'b1);
          else expected_q[expected_q.size()-1].last = 1'b1;
        end
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_result(sched_res_t got);
      sched_res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result kind=%0d slot=%0d handle=%h last=%0b",
                         got.kind, got.slot, got.handle, got.last));
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.kind == cts_pkg::KIND_RUN) runs_seen++;
      if (got.kind !== want.kind)
        report($sformatf("result %0d: kind %0d, want %0d", checked, got.kind, want.kind));
      if (got.slot !== want.slot)
        report($sformatf("result %0d: slot %0d, want %0d", checked, got.slot, want.slot));
      if (got.handle !== want.handle)
        report($sformatf("result %0d: handle %h, want %h", checked, got.handle, want.handle));
      if (got.last !== want.last)
        report($sformatf("result %0d: last %0b, want %0b", checked, got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;

  cts_in_if  in_chan ();
  cts_out_if out_chan ();

  cooperative_task_scheduler_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  sched_scoreboard board;
  int unsigned     src_idle_pct;
  int unsigned     snk_stall_pct;
  bit              hold_trigger;
  int unsigned     cmd_count[4];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result sink: random stalls, plus one long hold-off on request.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    sched_res_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.kind   = out_chan.result_kind;
      got.slot   = out_chan.slot_index;
      got.handle = out_chan.run_handle;
      got.last   = out_chan.last_of_run;
      board.check_result(got);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still owed", cycles,
             board.expected_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic sched_cmd_t mk_cmd(logic [cts_pkg::CMD_W-1:0] command,
                                        logic [cts_pkg::HANDLE_W-1:0] handle,
                                        logic [cts_pkg::DELAY_W-1:0] delay,
                                        logic [cts_pkg::DELAY_W-1:0] period,
                                        logic [cts_pkg::DEL_W-1:0] del_slot);
    sched_cmd_t c;
    c.command  = command;
    c.handle   = handle;
    c.delay    = delay;
    c.period   = period;
    c.del_slot = del_slot;
    return c;
  endfunction

  // Mostly short delays and periods so tasks come due; now and then full-range values.
  function automatic sched_cmd_t random_command();
    sched_cmd_t  c;
    int unsigned pick;
    pick       = $urandom_range(99);
    c.handle   = cts_pkg::HANDLE_W'($urandom_range(16'hFFFF));
    c.delay    = cts_pkg::DELAY_W'(($urandom_range(7) == 0) ? $urandom_range(16'hFFFF)
                                                            : $urandom_range(4));
    c.period   = cts_pkg::DELAY_W'(($urandom_range(7) == 0) ? $urandom_range(16'hFFFF)
                                                            : $urandom_range(4));
    c.del_slot = cts_pkg::DEL_W'($urandom_range(NSLOTS - 1));
    if (pick < 35)      c.command = cts_pkg::CMD_TICK;
    else if (pick < 60) c.command = cts_pkg::CMD_ADD;
    else if (pick < 72) c.command = cts_pkg::CMD_DELETE;
    else                c.command = cts_pkg::CMD_DISPATCH;
    if (c.command == cts_pkg::CMD_ADD && $urandom_range(15) == 0) c.handle = '0;
    return c;
  endfunction

  // Offer one command; return right after the edge that accepts it, valid still high.
  task automatic send_command(sched_cmd_t c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.command        <= c.command;
    in_chan.task_handle    <= c.handle;
    in_chan.first_delay    <= c.delay;
    in_chan.repeat_period  <= c.period;
    in_chan.slot_to_delete <= c.del_slot;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    board.note_command(c);
    cmd_count[c.command]++;
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned i;
    board         = new();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_trigger  = 1'b0;
    rst_n                  <= 1'b0;
    in_chan.valid          <= 1'b0;
    in_chan.command        <= cts_pkg::CMD_TICK;
    in_chan.task_handle    <= '0;
    in_chan.first_delay    <= '0;
    in_chan.repeat_period  <= '0;
    in_chan.slot_to_delete <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, refused adds, fill to full, one-shot repeats, deletes.
    send_command(mk_cmd(cts_pkg::CMD_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h0000, 16'h0000, 16'h0001, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'hFFFF, 16'h0000, 16'h0000, 3'd7));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h0001, 16'hFFFF, 16'hFFFF, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'hA5A5, 16'h0001, 16'h0001, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h5A5A, 16'h0000, 16'h0002, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h1234, 16'h0002, 16'h0000, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h8000, 16'h0000, 16'h0001, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h7FFF, 16'h0003, 16'h0003, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h0F0F, 16'h0000, 16'h0000, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h0042, 16'h0000, 16'h0000, 3'd0));
    repeat (4) send_command(mk_cmd(cts_pkg::CMD_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_DELETE, 16'h0, 16'h0, 16'h0, 3'd1));
    send_command(mk_cmd(cts_pkg::CMD_DELETE, 16'h0, 16'h0, 16'h0, 3'd1));
    send_command(mk_cmd(cts_pkg::CMD_ADD, 16'h0002, 16'h0000, 16'h0000, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));
    send_command(mk_cmd(cts_pkg::CMD_DELETE, 16'h0, 16'h0, 16'h0, 3'd7));

    // Saturation: eight tasks due every tick, pending counts driven past the top.
    src_idle_pct  = 6;
    snk_stall_pct = 6;
    for (i = 0; i < NSLOTS; i++)
      send_command(mk_cmd(cts_pkg::CMD_DELETE, 16'h0, 16'h0, 16'h0, cts_pkg::DEL_W'(i)));
    for (i = 0; i < NSLOTS; i++)
      send_command(mk_cmd(cts_pkg::CMD_ADD, cts_pkg::HANDLE_W'(16'h0100 + i), 16'h0000,
                          (i == 5) ? 16'h0000 : 16'h0001, 3'd0));
    for (i = 0; i < SAT_TICKS; i++)
      send_command(mk_cmd(cts_pkg::CMD_TICK, 16'h0, 16'h0, 16'h0, 3'd0));
    repeat (3) send_command(mk_cmd(cts_pkg::CMD_DISPATCH, 16'h0, 16'h0, 16'h0, 3'd0));

    // Random: free-running, bursty sender, stalling sink, light idling on both.
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1) ? 71 : (ph == 3) ? 6 : 0;
      snk_stall_pct = (ph == 2) ? 71 : (ph == 3) ? 6 : 0;
      // Hold the sink off while commands keep coming, so the block backs up.
      if (ph == 0) hold_trigger = 1'b1;
      for (i = 0; i < RAND_ITEMS / 4; i++) send_command(random_command());
    end
    in_chan.valid <= 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("commands: %0d tick, %0d add (%0d refused), %0d delete, %0d dispatch",
             cmd_count[cts_pkg::CMD_TICK], cmd_count[cts_pkg::CMD_ADD], board.refused_adds,
             cmd_count[cts_pkg::CMD_DELETE], cmd_count[cts_pkg::CMD_DISPATCH]);
    $display("results checked: %0d, task runs: %0d, ticks at pending limit: %0d",
             board.checked, board.runs_seen, board.sat_hits);
    if (board.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/cts_pkg.sv
hw/rtl/cts_chan_if.sv
hw/rtl/cts_slot_mem.sv
hw/rtl/cts_slot_alu.sv
hw/rtl/cooperative_task_scheduler_top.sv
dv/tb_cooperative_task_scheduler_top.sv
